FILE: hdl/rsl_pkg.sv
// ----------------------------------------------------------------------------
// rsl_pkg: shared types and constants for the RTP sequence loss tracker
// Stream table sizing, result kinds, lookup structs and FSM states.
// ----------------------------------------------------------------------------
package rsl_pkg;

  localparam int STREAMS     = 16;
  localparam int MISSED_SPAN = 32;

  localparam int IDX_W     = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int GAP_W     = $clog2(MISSED_SPAN);
  localparam int SID_W     = 32;
  localparam int SEQ_W     = 16;
  localparam int CNT_W     = 32;
  localparam int KIND_W    = 3;
  localparam int GAP_OUT_W = 5;
  localparam int ENTRY_W   = CNT_W + SEQ_W;   // {rollover, highest}

  localparam logic [SEQ_W-1:0] HALF_RANGE = 16'h8000;
  localparam int               GAP_SAT    = 31;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MISSING = 3'd0,
    KIND_FIRST   = 3'd1,
    KIND_ADVANCE = 3'd2,
    KIND_DUP     = 3'd3,
    KIND_LATE    = 3'd4,
    KIND_NOROOM  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EVAL,
    S_EMIT
  } state_t;

  // CAM search result
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    logic free;
    idx_t free_idx;
  } lookup_t;

  // new stream allocation request
  typedef struct packed {
    logic             en;
    idx_t             idx;
    logic [SID_W-1:0] sid;
  } alloc_t;

endpackage

FILE: hdl/rsl_if.sv
// ----------------------------------------------------------------------------
// rsl_if: valid/ready channels of the tracker
// Packet input channel and result output channel.
// ----------------------------------------------------------------------------
interface rsl_pkt_if;
  logic                      valid;
  logic                      ready;
  logic [rsl_pkg::SID_W-1:0] stream_id;
  logic [rsl_pkg::SEQ_W-1:0] seq_number;

  modport source (output valid, output stream_id, output seq_number, input ready);
  modport sink   (input valid, input stream_id, input seq_number, output ready);
endinterface

interface rsl_res_if;
  logic                          valid;
  logic                          ready;
  logic [rsl_pkg::KIND_W-1:0]    kind;
  logic [rsl_pkg::SEQ_W-1:0]     report_seq;
  logic [rsl_pkg::GAP_OUT_W-1:0] gap_losses;
  logic [rsl_pkg::CNT_W-1:0]     received_total;
  logic [rsl_pkg::CNT_W-1:0]     lost_total;
  logic                          last;

  modport source (output valid, output kind, output report_seq, output gap_losses,
                  output received_total, output lost_total, output last, input ready);
  modport sink   (input valid, input kind, input report_seq, input gap_losses,
                  input received_total, input lost_total, input last, output ready);
endinterface

FILE: hdl/rsl_ram.sv
// ----------------------------------------------------------------------------
// rsl_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rsl_stream_cam.sv
// ----------------------------------------------------------------------------
// rsl_stream_cam: stream identifier match table
// Valid bits and stream ids in flops; finds the matching and lowest free entry.
// ----------------------------------------------------------------------------
module rsl_stream_cam (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rsl_pkg::SID_W-1:0] sid,
  input  rsl_pkg::alloc_t           alloc,
  output rsl_pkg::lookup_t          lookup
);
  import rsl_pkg::*;

  logic [STREAMS-1:0] valid;
  logic [SID_W-1:0]   ids [STREAMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (alloc.en) begin
      valid[alloc.idx] <= 1'b1;
    end
    if (alloc.en) begin
      ids[alloc.idx] <= alloc.sid;
    end
  end

  // walk downward so the lowest index wins
  always_comb begin
    lookup = '0;
    for (int i = STREAMS - 1; i >= 0; i--) begin
      if (valid[i] && ids[i] == sid) begin
        lookup.hit     = 1'b1;
        lookup.hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        lookup.free     = 1'b1;
        lookup.free_idx = IDX_W'(i);
      end
    end
  end

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    lookup.hit |-> valid[lookup.hit_idx] && ids[lookup.hit_idx] == sid)
    else $error("cam hit on invalid or mismatched entry");

  a_free_clear: assert property (@(posedge clk) disable iff (rst)
    lookup.free |-> !valid[lookup.free_idx])
    else $error("cam free entry already valid");

  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    alloc.en |-> !valid[alloc.idx] && !lookup.hit)
    else $error("allocation over a live entry");

endmodule

FILE: hdl/rtp_sequence_loss_tracker.sv
// ----------------------------------------------------------------------------
// rtp_sequence_loss_tracker: per-stream RTP sequence tracking and loss report
// CAM lookup of the stream, read-modify-write of {rollover, highest} in RAM,
// then serial emission of missing-number words followed by a status word.
// ----------------------------------------------------------------------------
// Flow: the first word is loaded into the output register from the emit state,
//   after the accept, CAM lookup + RAM read and evaluate states.
// Throughput: one packet at a time, accepted only in idle; then one missing-number
//   word per cycle (at most MISSED_SPAN-1) while the output slot is free, set by
//   the one RAM read per packet and the single output register; back-pressure stalls.
// Reset: valid bits and both totals clear synchronously; RAM contents stay
//   undefined (never read before written), so no clearing pass is needed.
module rtp_sequence_loss_tracker (
  input  logic     clk,
  input  logic     rst,
  rsl_pkt_if.sink  pkt,
  rsl_res_if.source res
);
  import rsl_pkg::*;

  // ---------------------------------------------------------------- state
  state_t state, state_next;

  logic [SID_W-1:0] sid_q;
  logic [SEQ_W-1:0] seq_q;
  logic [CNT_W-1:0] packets_seen, packets_seen_next;
  logic [CNT_W-1:0] numbers_missed, numbers_missed_next;

  lookup_t lk_q;            // CAM result captured at lookup
  lookup_t lookup;

  kind_t            st_kind, st_kind_next;       // status word kind
  logic [SEQ_W-1:0] pend_seq, pend_seq_next;     // next missing number
  logic [GAP_W-1:0] miss_cnt, miss_cnt_next;     // numbers to report
  logic [GAP_W-1:0] gap_cnt, gap_cnt_next;       // numbers reported so far

  // output register
  logic                 res_valid, res_valid_next;
  kind_t                o_kind, o_kind_next;
  logic [SEQ_W-1:0]     o_seq, o_seq_next;
  logic [GAP_OUT_W-1:0] o_gap, o_gap_next;
  logic [CNT_W-1:0]     o_rcv, o_rcv_next;
  logic [CNT_W-1:0]     o_lost, o_lost_next;
  logic                 o_last, o_last_next;

  // RAM ports
  logic               ram_we;
  idx_t               ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  alloc_t             alloc;

  // -------------------------------------------------------- table parts
  rsl_stream_cam u_cam (
    .clk    (clk),
    .rst    (rst),
    .sid    (sid_q),
    .alloc  (alloc),
    .lookup (lookup)
  );

  // read issued during lookup at the CAM hit index; data valid in evaluate
  rsl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STREAMS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (lookup.hit_idx),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------- evaluate path
  logic [SEQ_W-1:0] old_seq;
  logic [CNT_W-1:0] old_roll;
  logic [SEQ_W-1:0] diff;
  logic             wrap;

  assign old_seq  = ram_rdata[SEQ_W-1:0];
  assign old_roll = ram_rdata[ENTRY_W-1:SEQ_W];
  assign diff     = seq_q - old_seq;          // modulo 2^16
  assign wrap     = seq_q < old_seq;

  logic accept;
  logic slot_free;

  assign pkt.ready = (state == S_IDLE);
  assign accept    = pkt.valid && pkt.ready;
  assign slot_free = !res_valid || res.ready;

  // ---------------------------------------------------------- sequencer
  always_comb begin
    state_next          = state;
    packets_seen_next   = packets_seen;
    numbers_missed_next = numbers_missed;
    st_kind_next        = st_kind;
    pend_seq_next       = pend_seq;
    miss_cnt_next       = miss_cnt;
    gap_cnt_next        = gap_cnt;
    res_valid_next      = res_valid && !res.ready;
    o_kind_next         = o_kind;
    o_seq_next          = o_seq;
    o_gap_next          = o_gap;
    o_rcv_next          = o_rcv;
    o_lost_next         = o_lost;
    o_last_next         = o_last;
    ram_we              = 1'b0;
    ram_waddr           = lk_q.hit_idx;
    ram_wdata           = {old_roll + CNT_W'(wrap), seq_q};
    alloc.en            = 1'b0;
    alloc.idx           = lk_q.free_idx;
    alloc.sid           = sid_q;

    case (state)
      S_IDLE: begin
        if (accept) begin
          packets_seen_next = packets_seen + CNT_W'(1);
          state_next        = S_LOOK;
        end
      end

      S_LOOK: begin
        state_next = S_EVAL;
      end

      S_EVAL: begin
        miss_cnt_next = '0;
        gap_cnt_next  = '0;
        pend_seq_next = old_seq + SEQ_W'(1);
        if (!lk_q.hit) begin
          if (lk_q.free) begin
            // new stream: highest = seq, rollover = 0
            st_kind_next = KIND_FIRST;
            alloc.en     = 1'b1;
            ram_we       = 1'b1;
            ram_waddr    = lk_q.free_idx;
            ram_wdata    = {CNT_W'(0), seq_q};
          end else begin
            st_kind_next = KIND_NOROOM;
          end
        end else if (diff == '0) begin
          st_kind_next = KIND_DUP;
        end else if (diff > HALF_RANGE) begin
          st_kind_next = KIND_LATE;
        end else begin
          // advance, half range included
          st_kind_next = KIND_ADVANCE;
          ram_we       = 1'b1;
          if (diff < SEQ_W'(MISSED_SPAN)) begin
            miss_cnt_next = GAP_W'(diff - SEQ_W'(1));
          end else begin
            miss_cnt_next = GAP_W'(MISSED_SPAN - 1);
          end
        end
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (slot_free) begin
          res_valid_next = 1'b1;
          o_rcv_next     = packets_seen;
          if (gap_cnt != miss_cnt) begin
            // one missing-number word
            numbers_missed_next = numbers_missed + CNT_W'(1);
            gap_cnt_next        = gap_cnt + GAP_W'(1);
            pend_seq_next       = pend_seq + SEQ_W'(1);
            o_kind_next         = KIND_MISSING;
            o_seq_next          = pend_seq;
            o_gap_next          = '0;
            o_lost_next         = numbers_missed + CNT_W'(1);
            o_last_next         = 1'b0;
          end else begin
            // closing status word
            o_kind_next = st_kind;
            o_seq_next  = seq_q;
            o_gap_next  = (gap_cnt > GAP_SAT) ? GAP_OUT_W'(GAP_SAT) : GAP_OUT_W'(gap_cnt);
            o_lost_next = numbers_missed;
            o_last_next = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      packets_seen   <= '0;
      numbers_missed <= '0;
      res_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      packets_seen   <= packets_seen_next;
      numbers_missed <= numbers_missed_next;
      res_valid      <= res_valid_next;
    end
  end

  // payload and working registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      sid_q <= pkt.stream_id;
      seq_q <= pkt.seq_number;
    end
    if (state == S_LOOK) begin
      lk_q <= lookup;
    end
    st_kind  <= st_kind_next;
    pend_seq <= pend_seq_next;
    miss_cnt <= miss_cnt_next;
    gap_cnt  <= gap_cnt_next;
    o_kind   <= o_kind_next;
    o_seq    <= o_seq_next;
    o_gap    <= o_gap_next;
    o_rcv    <= o_rcv_next;
    o_lost   <= o_lost_next;
    o_last   <= o_last_next;
  end

  assign res.valid          = res_valid;
  assign res.kind           = o_kind;
  assign res.report_seq     = o_seq;
  assign res.gap_losses     = o_gap;
  assign res.received_total = o_rcv;
  assign res.lost_total     = o_lost;
  assign res.last           = o_last;

  // --------------------------------------------------------- assertions
  a_missing_word: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.last |-> res.kind == KIND_MISSING && res.gap_losses == '0)
    else $error("non-final word is not a clean missing-number word");

  a_count_packet: assert property (@(posedge clk) disable iff (rst)
    accept |=> packets_seen == $past(packets_seen) + CNT_W'(1))
    else $error("packet not counted on accept");

  a_gap_on_advance: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && gap_cnt != miss_cnt |-> st_kind == KIND_ADVANCE)
    else $error("missing numbers pending on a non-advance packet");

endmodule

FILE: dv/rtp_sequence_loss_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_sequence_loss_tracker_checker: word-level predictor and comparator
// Watches the packet and result channels. Each accepted packet updates a
// private copy of the stream table and queues the words it should produce.
// Each accepted result word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module rtp_sequence_loss_tracker_checker
  import rsl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rsl_pkt_if   pkt,
  rsl_res_if   res,
  output int   fail_count,
  output int   outstanding,
  output int   packet_count,
  output int   word_count,
  output int   miss_count,
  output int   wrap_count,
  output int   noroom_count
);

  typedef struct {
    kind_t                kind;
    logic [SEQ_W-1:0]     report_seq;
    logic [GAP_OUT_W-1:0] gap_losses;
    logic [CNT_W-1:0]     received_total;
    logic [CNT_W-1:0]     lost_total;
    logic                 last;
  } report_t;

  // shadow stream table
  logic             stream_live  [STREAMS];
  logic [SID_W-1:0] stream_tag   [STREAMS];
  logic [SEQ_W-1:0] stream_high  [STREAMS];
  logic [CNT_W-1:0] stream_wraps [STREAMS];
  logic [CNT_W-1:0] packets_seen;
  logic [CNT_W-1:0] numbers_missed;

  report_t pending_reports[$];

  function automatic report_t make_report(kind_t kind, logic [SEQ_W-1:0] seq, int gap,
                                          logic last_word);
    report_t r;
    r.kind           = kind;
    r.report_seq     = seq;
    r.gap_losses     = GAP_OUT_W'((gap > GAP_SAT) ? GAP_SAT : gap);
    r.received_total = packets_seen;
    r.lost_total     = numbers_missed;
    r.last           = last_word;
    return r;
  endfunction

  // append one expected word at the tail
  function automatic void queue_report(report_t r);
    pending_reports = {pending_reports, r};
  endfunction

  // Lookup, classify, then queue missing-number words and the status word.
  task automatic track_packet(input logic [SID_W-1:0] sid, input logic [SEQ_W-1:0] seq);
    int               hit;
    int               free_slot;
    int               span;
    int               gap;
    logic [SEQ_W-1:0] old;
    logic [SEQ_W-1:0] diff;
    hit       = -1;
    free_slot = -1;
    gap       = 0;
    packets_seen++;
    packet_count++;
    for (int i = 0; i < STREAMS; i++) begin
      if (stream_live[i]) begin
        if (hit < 0 && stream_tag[i] == sid) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        queue_report(make_report(KIND_NOROOM, seq, 0, 1'b1));
        noroom_count++;
      end else begin
        stream_live[free_slot]  = 1'b1;
        stream_tag[free_slot]   = sid;
        stream_high[free_slot]  = seq;
        stream_wraps[free_slot] = '0;
        queue_report(make_report(KIND_FIRST, seq, 0, 1'b1));
      end
    end else begin
      old  = stream_high[hit];
      diff = seq - old;
      if (diff == '0) begin
        queue_report(make_report(KIND_DUP, seq, 0, 1'b1));
      end else if (diff > HALF_RANGE) begin
        queue_report(make_report(KIND_LATE, seq, 0, 1'b1));
      end else begin
        span = (diff < MISSED_SPAN) ? int'(diff) : MISSED_SPAN;
        for (int m = 1; m < span; m++) begin
          numbers_missed++;
          gap++;
          miss_count++;
          queue_report(make_report(KIND_MISSING, old + SEQ_W'(m), 0, 1'b0));
        end
        if (seq < old) begin
          stream_wraps[hit]++;
          wrap_count++;
        end
        stream_high[hit] = seq;
        queue_report(make_report(KIND_ADVANCE, seq, gap, 1'b1));
      end
    end
  endtask

  task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      for (int i = 0; i < STREAMS; i++) stream_live[i] = 1'b0;
      packets_seen   = '0;
      numbers_missed = '0;
      pending_reports.delete();
      outstanding <= 0;
    end else begin
      // results first: a stray word must not match the packet accepted now
      if (res.valid && res.ready) begin
        word_count++;
        if (pending_reports.size() == 0) begin
          $error("result word with nothing pending: kind %0d seq 0x%0h",
                 res.kind, res.report_seq);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("kind", want.kind, res.kind);
          check_field("report_seq", want.report_seq, res.report_seq);
          check_field("gap_losses", want.gap_losses, res.gap_losses);
          check_field("received_total", want.received_total, res.received_total);
          check_field("lost_total", want.lost_total, res.lost_total);
          check_field("last", want.last, res.last);
        end
      end
      if (pkt.valid && pkt.ready) track_packet(pkt.stream_id, pkt.seq_number);
      outstanding <= pending_reports.size();
    end
  end

endmodule

FILE: dv/rtp_sequence_loss_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_sequence_loss_tracker_tb: regression bench for the loss tracker
// Directed packets hit duplicates, late arrivals, the half-range advance,
// gap capping, sequence wrap and a full stream table; random packets then
// walk the table under varied idling and back-pressure. A separate checker
// predicts every result word and compares it.
// ----------------------------------------------------------------------------
module rtp_sequence_loss_tracker_tb;
  import rsl_pkg::*;

  localparam int PHASE_PACKETS = 50;       // three phases, ~150 random after ~30 directed
  localparam int HOLD_CYCLES   = 300;      // long output hold-off
  localparam int SETTLE_CYCLES = 8;        // idle margin after the final drain
  localparam int CYCLE_LIMIT   = 500_000;

  logic clk;
  logic rst;

  rsl_pkt_if pkt_ch ();
  rsl_res_if res_ch ();

  rtp_sequence_loss_tracker dut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt_ch),
    .res (res_ch)
  );

  int fail_count;
  int pending_words;
  int packet_count;
  int word_count;
  int miss_count;
  int wrap_count;
  int noroom_count;

  rtp_sequence_loss_tracker_checker loss_check (
    .clk          (clk),
    .rst          (rst),
    .pkt          (pkt_ch),
    .res          (res_ch),
    .fail_count   (fail_count),
    .outstanding  (pending_words),
    .packet_count (packet_count),
    .word_count   (word_count),
    .miss_count   (miss_count),
    .wrap_count   (wrap_count),
    .noroom_count (noroom_count)
  );

  // idle percentages, changed only between phases with the block drained
  int send_idle_pct;
  int recv_idle_pct;
  // hold-off request count (stimulus side) vs. served count (receiver side)
  int hold_req;
  int hold_served;
  int cycle_count;

  // stimulus-side view of the streams it has opened: id and highest number
  logic             pool_live [STREAMS];
  logic [SID_W-1:0] pool_sid  [STREAMS];
  logic [SEQ_W-1:0] pool_high [STREAMS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random ready, or a long hold-off counted here when asked.
  // While it holds, the block's single output register and packet slot fill
  // and pkt.ready drops, so the input side sees real back-pressure.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_served) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic is_pooled(logic [SID_W-1:0] sid);
    for (int i = 0; i < STREAMS; i++)
      if (pool_sid[i] === sid) return 1'b1;
    return 1'b0;
  endfunction

  // Offer one packet word; random idle cycles ahead of it, then wait for the
  // handshake. valid stays high on return so back-to-back words need no dip.
  task automatic send_packet(input logic [SID_W-1:0] sid, input logic [SEQ_W-1:0] seq);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pkt_ch.valid      <= 1'b1;
    pkt_ch.stream_id  <= sid;
    pkt_ch.seq_number <= seq;
    do @(posedge clk); while (pkt_ch.ready !== 1'b1);
  endtask

  // Send on a pooled stream and keep the local highest number in step, so
  // random packets are built as offsets from where the stream really is.
  task automatic send_tracked(input int slot, input logic [SEQ_W-1:0] seq);
    logic [SEQ_W-1:0] step;
    step = seq - pool_high[slot];
    send_packet(pool_sid[slot], seq);
    if (!pool_live[slot]) begin
      pool_live[slot] = 1'b1;
      pool_high[slot] = seq;
    end else if (step != '0 && step <= HALF_RANGE) begin
      pool_high[slot] = seq;
    end
  endtask

  // Mostly well-formed traffic on known streams: small steps, gaps of all
  // sizes, duplicates and late packets; some noise and unknown streams.
  task automatic send_random();
    int               pick;
    int               slot;
    logic [SID_W-1:0] sid;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] seq;
    pick = $urandom_range(99);
    slot = $urandom_range(STREAMS-1);
    base = pool_high[slot];
    if (pick < 5) begin
      // unknown stream while the table is full
      do sid = $urandom; while (is_pooled(sid));
      send_packet(sid, SEQ_W'($urandom));
    end else begin
      if (pick < 45)      seq = base + SEQ_W'($urandom_range(3, 1));
      else if (pick < 60) seq = base + SEQ_W'($urandom_range(40, 4));
      else if (pick < 63) seq = base + SEQ_W'($urandom_range(16'h7FFF, 41));
      else if (pick < 65) seq = base + HALF_RANGE;
      else if (pick < 75) seq = base;
      else if (pick < 87) seq = base - SEQ_W'($urandom_range(16'h7FFF, 1));
      else                seq = SEQ_W'($urandom);
      send_tracked(slot, seq);
    end
  endtask

  // Stop offering and wait until every predicted word has been taken.
  task automatic drain();
    pkt_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  initial begin
    logic [SID_W-1:0] fresh;
    rst               <= 1'b1;
    pkt_ch.valid      <= 1'b0;
    pkt_ch.stream_id  <= '0;
    pkt_ch.seq_number <= '0;
    hold_req          <= 0;
    send_idle_pct      = 27;
    recv_idle_pct      = 56;
    for (int i = 0; i < STREAMS; i++) pool_live[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: all-zero stream id
    pool_sid[0] = '0;
    send_tracked(0, 16'h0000);   // first of stream
    send_tracked(0, 16'h0000);   // duplicate
    send_tracked(0, 16'h0001);   // advance, no gap
    send_tracked(0, 16'hFFFF);   // late, two behind the highest
    send_tracked(0, 16'h8001);   // exactly half range: advance, gap capped
    send_tracked(0, 16'h0001);   // half range again, numerically below: wrap
    send_tracked(0, 16'h0005);   // three missing
    // directed: all-ones stream id
    pool_sid[1] = '1;
    send_tracked(1, 16'hFFFF);   // first of stream at top of range
    send_tracked(1, 16'h0000);   // wrap with no gap
    send_tracked(1, 16'h0020);   // gap right at the span: 31 missing
    send_tracked(1, 16'h0061);   // gap past the span: still 31
    send_tracked(1, 16'h0060);   // late by one
    send_tracked(1, 16'h8060);   // largest advance short of half range
    // fill the rest of the table, then one stream with no room left
    for (int slot = 2; slot < STREAMS; slot++) begin
      do fresh = $urandom; while (is_pooled(fresh));
      pool_sid[slot] = fresh;
      send_tracked(slot, SEQ_W'($urandom));
    end
    do fresh = $urandom; while (is_pooled(fresh));
    send_packet(fresh, 16'hFFFF);
    drain();   // sender pause until every word is back

    // random: sender-light/receiver-heavy idling, then swapped, then none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_PACKETS; n++) begin
        if (phase == 0 && n == 10) hold_req <= hold_req + 1;
        send_random();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d packets and %0d result words:", packet_count, word_count);
    $display("  %0d missing numbers, %0d wraps, %0d no-room", miss_count, wrap_count,
             noroom_count);
    $display("Idling mixes: receiver-heavy, sender-heavy and none, plus a %0d-cycle hold",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_words == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
